// ===== hdl/k2s_pkg.sv =====
// Types, constants and scan code tables shared by the scan code encoder.
`default_nettype none
package k2s_pkg;

  // Key codes with fixed sequences
  localparam logic [9:0] KC_SYSRQ      = 10'd99;
  localparam logic [9:0] KC_PAUSE      = 10'd119;
  localparam int         TABLE_ENTRIES = 128;
  localparam int         TABLE_AW      = $clog2(TABLE_ENTRIES);

  localparam logic [7:0] PREFIX_EXT = 8'he0;
  localparam logic [7:0] PREFIX_BRK = 8'hf0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_NO_BREAK = 2'd2,
    ST_NO_ROOM  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEQ_PLAIN,
    SEQ_SYSRQ,
    SEQ_PAUSE,
    SEQ_ERROR
  } seq_kind_t;

  // Input beat
  typedef struct packed {
    logic       kind;
    logic [9:0] key_code;
    logic [3:0] buffer_room;
  } cmd_t;

  // Output beat
  typedef struct packed {
    logic [7:0] code_byte;
    logic [3:0] sequence_length;
    status_t    status;
    logic       last;
  } result_t;

  // Classified event handed from front to back
  typedef struct packed {
    seq_kind_t  seq_kind;
    logic       brk;
    logic       ext;
    logic [7:0] code;
    logic [3:0] len;
    logic [2:0] last_idx;
    status_t    status;
  } desc_t;

  localparam logic [7:0] SYSRQ_MAKE_SEQ [8] = '{
    8'he0, 8'h12, 8'he0, 8'h7c, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] SYSRQ_BRK_SEQ [8] = '{
    8'he0, 8'hf0, 8'h7c, 8'he0, 8'hf0, 8'h12, 8'h00, 8'h00};
  localparam logic [7:0] PAUSE_SEQ [8] = '{
    8'he1, 8'h14, 8'h77, 8'he1, 8'hf0, 8'h14, 8'hf0, 8'h77};

  // Make codes by key code; upper byte holds the extended prefix
  localparam logic [15:0] MAKE_TABLE [TABLE_ENTRIES] = '{
    16'h0000, 16'h0076, 16'h0016, 16'h001e, 16'h0026, 16'h0025, 16'h002e, 16'h0036,
    16'h003d, 16'h003e, 16'h0046, 16'h0045, 16'h004e, 16'h0055, 16'h0066, 16'h000d,
    16'h0015, 16'h001d, 16'h0024, 16'h002d, 16'h002c, 16'h0035, 16'h003c, 16'h0043,
    16'h0044, 16'h004d, 16'h0054, 16'h005b, 16'h005a, 16'h0014, 16'h001c, 16'h001b,
    16'h0023, 16'h002b, 16'h0034, 16'h0033, 16'h003b, 16'h0042, 16'h004b, 16'h004c,
    16'h0052, 16'h000e, 16'h0012, 16'h005d, 16'h001a, 16'h0022, 16'h0021, 16'h002a,
    16'h0032, 16'h0031, 16'h003a, 16'h0041, 16'h0049, 16'h004a, 16'h0059, 16'h007c,
    16'h0011, 16'h0029, 16'h0058, 16'h0005, 16'h0006, 16'h0004, 16'h000c, 16'h0003,
    16'h000b, 16'h0083, 16'h000a, 16'h0001, 16'h0009, 16'h0077, 16'h007e, 16'h006c,
    16'h0075, 16'h007d, 16'h007b, 16'h006b, 16'h0073, 16'h0074, 16'h0079, 16'h0069,
    16'h0072, 16'h007a, 16'h0070, 16'h0071, 16'h0000, 16'h0000, 16'h0000, 16'h0078,
    16'h0007, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'he05a, 16'he014, 16'he04a, 16'h0000, 16'he011, 16'h0000, 16'he06c, 16'he075,
    16'he07d, 16'he06b, 16'he074, 16'he069, 16'he072, 16'he07a, 16'he070, 16'he071,
    16'h0000, 16'he023, 16'he021, 16'he032, 16'he05e, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'he01f, 16'he027, 16'h0000
  };

  // Byte at position idx of the sequence a descriptor stands for
  function automatic logic [7:0] seq_byte(input desc_t d, input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (d.seq_kind)
      SEQ_SYSRQ: b = d.brk ? SYSRQ_BRK_SEQ[idx] : SYSRQ_MAKE_SEQ[idx];
      SEQ_PAUSE: b = PAUSE_SEQ[idx];
      SEQ_PLAIN: begin
        if (d.ext && (idx == 3'd0)) b = PREFIX_EXT;
        else if (d.brk && ({1'b0, idx} == (d.len - 4'd2))) b = PREFIX_BRK;
        else b = d.code;
      end
      SEQ_ERROR: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/k2s_front.sv =====
// Front end: classifies a key event into a sequence descriptor.
`default_nettype none
module k2s_front
  import k2s_pkg::*;
(
  input  cmd_t  cmd,
  output desc_t desc
);

  logic [15:0] entry;
  logic        ext;
  logic [3:0]  len;
  logic        out_of_table;

  // Look up the make code
  always_comb begin
    out_of_table = (cmd.key_code >= 10'(TABLE_ENTRIES));
    entry        = MAKE_TABLE[cmd.key_code[TABLE_AW-1:0]];
    ext          = (entry[15:8] == PREFIX_EXT);
  end

  // Classify, then check room
  always_comb begin
    desc          = '0;
    desc.brk      = cmd.kind;
    desc.ext      = ext;
    desc.code     = entry[7:0];
    desc.status   = ST_OK;
    desc.seq_kind = SEQ_PLAIN;
    len           = 4'd1 + {3'd0, ext} + {3'd0, cmd.kind};
    priority if (cmd.key_code == KC_SYSRQ) begin
      desc.seq_kind = SEQ_SYSRQ;
      len           = cmd.kind ? 4'd6 : 4'd4;
    end else if (cmd.key_code == KC_PAUSE) begin
      desc.seq_kind = SEQ_PAUSE;
      len           = 4'd8;
      if (cmd.kind) begin
        desc.seq_kind = SEQ_ERROR;
        desc.status   = ST_NO_BREAK;
      end
    end else if (out_of_table || (entry == 16'h0000)) begin
      desc.seq_kind = SEQ_ERROR;
      desc.status   = ST_UNKNOWN;
    end else begin
      desc.seq_kind = SEQ_PLAIN;
    end
    if ((desc.seq_kind != SEQ_ERROR) && (len > cmd.buffer_room)) begin
      desc.seq_kind = SEQ_ERROR;
      desc.status   = ST_NO_ROOM;
    end
    if (desc.seq_kind == SEQ_ERROR) begin
      desc.len      = 4'd0;
      desc.last_idx = 3'd0;
    end else begin
      desc.len      = len;
      desc.last_idx = 3'(len - 4'd1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/k2s_queue.sv =====
// Two-entry descriptor queue between front and back.
`default_nettype none
module k2s_queue
  import k2s_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  input  logic  pop,
  output desc_t head,
  output logic  full,
  output logic  empty
);

  desc_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  // Store a beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/k2s_back.sv =====
// Back end: walks a descriptor and emits one scan code byte per cycle.
`default_nettype none
module k2s_back
  import k2s_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  desc_t   head,
  input  logic    empty,
  output logic    pop,
  output logic    result_valid,
  output result_t result
);

  desc_t      cur;
  logic       active;
  logic [2:0] idx;
  logic       cur_last;

  // Take the next descriptor when idle or on the final byte
  always_comb begin
    cur_last = (idx == cur.last_idx);
    pop      = !empty && (!active || cur_last);
  end

  // Hold the current descriptor and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 3'd0;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= 3'd0;
    end else if (active) begin
      if (cur_last) active <= 1'b0;
      else          idx    <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  // Register the output beat
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= active;
  end

  always_ff @(posedge clk) begin
    if (active) begin
      result.code_byte       <= seq_byte(cur, idx);
      result.sequence_length <= cur.len;
      result.status          <= cur.status;
      result.last            <= cur_last;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/keycode_to_ps2_set2_scancode.sv =====
// Top level of the key code to set 2 scan code encoder.
// When the block is idle, a start beat is registered in the queue, then loaded by the
// sequencer, and its first byte is then taken by the output register.
// Throughput: one byte per cycle; an event gives one beat per byte (one beat for an error),
// set by the byte sequencer in the back end. Queued events follow each other with no gap.
// busy rises only while the two-entry descriptor queue is full.
// Reset (synchronous, active high) empties the queue and idles the sequencer.
`default_nettype none
module keycode_to_ps2_set2_scancode
  import k2s_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    result_valid,
  output result_t result
);

  desc_t desc;
  desc_t head;
  logic  full;
  logic  empty;
  logic  pop;
  logic  push;

  assign busy = full;
  assign push = start && !full;

  k2s_front u_front (
    .cmd  (cmd),
    .desc (desc)
  );

  k2s_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (desc),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  k2s_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== hdl/k2s_checker.sv =====
// Port-level checker for the scan code encoder, bound to the top level.
`default_nettype none
module k2s_checker
  import k2s_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input logic    result_valid,
  input result_t result
);

  // A taken start beat carries a known key event
  a_cmd_known: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown(cmd))
    else $error("start beat with unknown fields");

  // An error beat is alone and carries no byte
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_OK)) |->
      (result.last && (result.code_byte == 8'h00) && (result.sequence_length == 4'd0)))
    else $error("error beat malformed");

  // A good beat belongs to a sequence of one to eight bytes
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == ST_OK)) |->
      ((result.sequence_length != 4'd0) && (result.sequence_length <= 4'd8)))
    else $error("bad sequence length");

  // Bytes of one sequence leave back to back with the same length
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=>
      (result_valid && (result.sequence_length == $past(result.sequence_length))))
    else $error("sequence broken");

  // A one-byte sequence is its own last beat
  a_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.sequence_length == 4'd1)) |-> result.last)
    else $error("one-byte sequence not marked last");

endmodule

bind keycode_to_ps2_set2_scancode k2s_checker u_k2s_checker (.*);
`default_nettype wire
